[rtl/lfu_pkg.sv]
// lfu_pkg: shared constants for the LFU cache table.
// Used by the channel interfaces, the entry RAM and the top level.
`timescale 1ns / 1ps

package lfu_pkg;

    // Default number of entries.
    localparam int CAPACITY_DEF = 16;

    // Payload widths.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int CFG_W = 5;

    // Reset value of the capacity register.
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Saturation point of a use count.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Value returned by a get that misses.
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    // Operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

endpackage

[rtl/lfu_ifs.sv]
// lfu_ifs: request and response channel interfaces of the LFU cache table.
// Depends on lfu_pkg for payload widths.
`timescale 1ns / 1ps

interface lfu_req_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [lfu_pkg::KEY_W-1:0]  lookup_key;
    logic signed [lfu_pkg::VAL_W-1:0]  store_value;

    modport source (output valid, operation, lookup_key, store_value, input ready);
    modport sink   (input valid, operation, lookup_key, store_value, output ready);
endinterface

interface lfu_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              key_found;
    logic signed [lfu_pkg::VAL_W-1:0]  read_value;
    logic                              did_evict;
    logic signed [lfu_pkg::KEY_W-1:0]  evicted_key;

    modport source (output valid, key_found, read_value, did_evict, evicted_key, input ready);
    modport sink   (input valid, key_found, read_value, did_evict, evicted_key, output ready);
endinterface

[rtl/lfu_entry_ram.sv]
// lfu_entry_ram: one-write one-read entry store with registered read data.
// Depends on lfu_pkg for the default depth; widths come from the instantiating module.
`timescale 1ns / 1ps

module lfu_entry_ram #(
    parameter int DEPTH = lfu_pkg::CAPACITY_DEF,
    parameter int AW    = 4,
    parameter int DW    = 100
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lfu_cache_table.sv]
// lfu_cache_table: LFU key-value cache with LRU tie break, entries in one RAM.
// Sequence: a get miss runs a lookup pass only, every other operation a lookup pass
// and then a rank update pass; one operation at a time, set by the single RAM read port
// that a lookup pass and a rank update pass each sweep once per entry.
// Reset: synchronous, active low; valid bits and occupancy clear at once, no clearing pass.
// Depends on lfu_pkg, lfu_ifs and lfu_entry_ram.
`timescale 1ns / 1ps

module lfu_cache_table #(
    parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]  i_cfg_wdata,
    lfu_req_if.sink                    i_req,
    lfu_rsp_if.source                  o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = AW;
    localparam int EW = (CW > lfu_pkg::CFG_W) ? CW : lfu_pkg::CFG_W;
    localparam int KW = lfu_pkg::KEY_W;
    localparam int VW = lfu_pkg::VAL_W;
    localparam int NW = lfu_pkg::CNT_W;
    localparam int DW = KW + VW + NW + RW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CNT_END   = CW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DEC  = 5'b00100,
        S_UPD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state;
    logic               r_op;
    logic [KW-1:0]      r_key;
    logic [VW-1:0]      r_val;
    logic [CW-1:0]      r_cnt;
    logic               r_pend;
    logic [AW-1:0]      r_paddr;
    logic [CAPACITY-1:0] r_valid;
    logic [CW-1:0]      r_filled;
    logic [lfu_pkg::CFG_W-1:0] r_cap;

    logic               r_found;
    logic [AW-1:0]      r_hit;
    logic [RW-1:0]      r_hrank;
    logic [VW-1:0]      r_hval;
    logic               r_have_v;
    logic [AW-1:0]      r_vic;
    logic [NW-1:0]      r_vcnt;
    logic [RW-1:0]      r_vrank;
    logic [KW-1:0]      r_vkey;
    logic               r_have_free;
    logic [AW-1:0]      r_free;
    logic               r_evict;
    logic [AW-1:0]      r_tgt;

    logic               r_ovalid;
    logic               r_ofound;
    logic [VW-1:0]      r_oval;
    logic               r_oevict;
    logic [KW-1:0]      r_okey;

    logic [DW-1:0]      rdata;
    logic [KW-1:0]      d_key;
    logic [VW-1:0]      d_val;
    logic [NW-1:0]      d_cnt;
    logic [RW-1:0]      d_rank;
    logic               d_valid;

    logic [EW-1:0]      cap_x;
    logic [EW-1:0]      eff_cap;
    logic               n_evict;
    logic [AW-1:0]      n_slot;
    logic               accept;
    logic               out_free;
    logic               issue;

    logic               ram_we;
    logic [DW-1:0]      ram_wdata;
    logic [RW-1:0]      n_rank;
    logic [NW-1:0]      n_count;
    logic [VW-1:0]      n_value;

    // Split the RAM word.
    assign d_key   = rdata[DW-1 -: KW];
    assign d_val   = rdata[DW-KW-1 -: VW];
    assign d_cnt   = rdata[NW+RW-1 -: NW];
    assign d_rank  = rdata[RW-1:0];
    assign d_valid = r_valid[r_paddr];

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign issue    = (r_state == S_SCAN || r_state == S_UPD) && (r_cnt != CNT_END);

    // Clamp the capacity register into 1 .. CAPACITY.
    always_comb begin
        cap_x = EW'(r_cap);
        if (cap_x == '0) begin
            eff_cap = EW'(1);
        end else if (cap_x > EW'(CAPACITY)) begin
            eff_cap = EW'(CAPACITY);
        end else begin
            eff_cap = cap_x;
        end
    end

    // Decide eviction and the insert slot from the scan results.
    always_comb begin
        n_evict = (r_op == lfu_pkg::OP_PUT) && !r_found &&
                  (EW'(r_filled) >= eff_cap) && (r_filled != '0) && r_have_v;
        if (n_evict) begin
            n_slot = (r_have_free && r_free < r_vic) ? r_free : r_vic;
        end else begin
            n_slot = r_free;
        end
    end

    // Build the write-back word for the entry under update.
    always_comb begin
        n_count   = (d_cnt == lfu_pkg::CNT_MAX) ? d_cnt : d_cnt + NW'(1);
        n_value   = (r_op == lfu_pkg::OP_PUT) ? r_val : d_val;
        n_rank    = d_rank;
        ram_we    = 1'b0;
        ram_wdata = rdata;
        if (r_state == S_UPD && r_pend) begin
            if (r_paddr == r_tgt) begin
                ram_we = 1'b1;
                if (r_found) begin
                    ram_wdata = {r_key, n_value, n_count, RW'(0)};
                end else begin
                    ram_wdata = {r_key, r_val, NW'(1), RW'(0)};
                end
            end else if (d_valid) begin
                ram_we = 1'b1;
                if (r_found) begin
                    n_rank = (d_rank < r_hrank) ? d_rank + RW'(1) : d_rank;
                end else if (r_evict && d_rank > r_vrank) begin
                    n_rank = d_rank;
                end else begin
                    n_rank = d_rank + RW'(1);
                end
                ram_wdata = {d_key, d_val, d_cnt, n_rank};
            end
        end
    end

    lfu_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_paddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rdata)
    );

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lfu_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Sequencer, sweep counter and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_valid  <= '0;
            r_filled <= '0;
        end else begin
            // Advance the sweep one entry a beat.
            if (issue) begin
                r_cnt   <= r_cnt + CW'(1);
                r_paddr <= r_cnt[AW-1:0];
                r_pend  <= 1'b1;
            end else begin
                r_pend  <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_pend && r_paddr == LAST_ADDR) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    if (r_op == lfu_pkg::OP_GET && !r_found) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_UPD;
                    end
                    if (r_op == lfu_pkg::OP_PUT && !r_found) begin
                        if (n_evict) begin
                            r_valid[r_vic] <= 1'b0;
                        end else begin
                            r_filled <= r_filled + CW'(1);
                        end
                        r_valid[n_slot] <= 1'b1;
                    end
                end
                S_UPD: begin
                    if (r_pend && r_paddr == LAST_ADDR) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the request and track hit, victim and free slot during the scan.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_req.operation;
            r_key       <= i_req.lookup_key;
            r_val       <= i_req.store_value;
            r_found     <= 1'b0;
            r_have_v    <= 1'b0;
            r_have_free <= 1'b0;
            r_evict     <= 1'b0;
        end else if (r_state == S_SCAN && r_pend) begin
            if (d_valid && d_key == r_key && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= r_paddr;
                r_hrank <= d_rank;
                r_hval  <= d_val;
            end
            if (d_valid && (!r_have_v || d_cnt < r_vcnt ||
                            (d_cnt == r_vcnt && d_rank > r_vrank))) begin
                r_have_v <= 1'b1;
                r_vic    <= r_paddr;
                r_vcnt   <= d_cnt;
                r_vrank  <= d_rank;
                r_vkey   <= d_key;
            end
            if (!d_valid && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free      <= r_paddr;
            end
        end else if (r_state == S_DEC) begin
            r_evict <= n_evict;
            r_tgt   <= r_found ? r_hit : n_slot;
        end
    end

    // Output register: load the result beat, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_ofound <= r_found;
            if (r_op == lfu_pkg::OP_GET) begin
                r_oval <= r_found ? r_hval : lfu_pkg::MISS_VALUE;
            end else begin
                r_oval <= '0;
            end
            r_oevict <= r_evict;
            r_okey   <= r_evict ? r_vkey : '0;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.key_found   = r_ofound;
    assign o_rsp.read_value  = r_oval;
    assign o_rsp.did_evict   = r_oevict;
    assign o_rsp.evicted_key = r_okey;

    // Occupancy always matches the number of valid entries.
    a_filled_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_filled))
        else $error("occupancy differs from valid bit count");

    // Occupancy never exceeds the table size.
    a_filled_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_filled) <= CAPACITY)
        else $error("occupancy above capacity");

    // An accepted request starts a lookup pass.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN && r_cnt == '0))
        else $error("accepted request did not start a scan");

    // Occupancy changes only on a put that misses and does not evict.
    a_filled_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DEC) |=> $stable(r_filled))
        else $error("occupancy changed outside the decision step");

endmodule
